// ----- hdl/ilt_pkg.sv -----
`default_nettype none

package ilt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W_DEF   = 32;

    localparam int FUNC_W   = 3;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int RDATA_W  = 32;
    localparam int COUNT_W  = 7;

    typedef enum logic [FUNC_W-1:0] {
        F_GET    = 3'd0,
        F_SET    = 3'd1,
        F_APPEND = 3'd2,
        F_OREM   = 3'd3,
        F_SREM   = 3'd4,
        F_CLEAR  = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_OOB  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [RDATA_W-1:0]    read_data;
        logic [COUNT_W-1:0]    count;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/ilt_step.sv -----
`default_nettype none

// Shared increment and compare unit of the sequencer.
module ilt_step #(
    parameter int W = 7
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic      [W-1:0] o_inc,
    output logic              o_lt
);

    assign o_inc = i_a + W'(1);
    assign o_lt  = (i_a < i_b);

endmodule

`default_nettype wire

// ----- hdl/ilt_ram.sv -----
`default_nettype none

module ilt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/ilt_seq.sv -----
`default_nettype none

module ilt_seq #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int XW = (ilt_pkg::INDEX_W > CW) ? ilt_pkg::INDEX_W : CW
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ilt_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [ilt_pkg::INDEX_W-1:0]   i_index,
    input  wire logic [ilt_pkg::VALUE_W-1:0]   i_write_value,
    output logic                               o_mem_we,
    output logic      [AW-1:0]                 o_mem_waddr,
    output logic      [DATA_WIDTH-1:0]         o_mem_wdata,
    output logic      [AW-1:0]                 o_mem_raddr,
    input  wire logic [DATA_WIDTH-1:0]         i_mem_rdata,
    output logic      [XW-1:0]                 o_step_a,
    output logic      [XW-1:0]                 o_step_b,
    input  wire logic [XW-1:0]                 i_step_inc,
    input  wire logic                          i_step_lt,
    output logic                               o_res_valid,
    output ilt_pkg::t_result                   o_res,
    input  wire logic                          i_res_take
);

    import ilt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_SWAP  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_idx, n_idx;
    logic [AW-1:0]        r_src, n_src;
    t_status              r_status, n_status;
    logic [RDATA_W-1:0]   r_rdata, n_rdata;

    logic [XW-1:0]        idx_x;
    logic [AW-1:0]        idx_a;
    logic [CW-1:0]        cnt_dec;
    logic                 in_bnd;
    logic                 not_last;
    logic                 full;

    assign idx_x    = XW'(i_index);
    assign idx_a    = idx_x[AW-1:0];
    assign cnt_dec  = r_count - CW'(1);
    // step unit compares the index against the count while idle
    assign in_bnd   = i_step_lt && (idx_x < XW'(CAPACITY));
    assign not_last = (idx_x != XW'(cnt_dec));
    assign full     = (r_count == CW'(CAPACITY));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_src       = r_src;
        n_status    = r_status;
        n_rdata     = r_rdata;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = '0;
        o_step_a    = XW'(r_src);
        o_step_b    = XW'(r_count);

        case (r_state)
            S_IDLE: begin
                o_step_a = idx_x;
                if (i_in_valid) begin
                    n_status = ST_OK;
                    n_rdata  = '0;
                    n_state  = S_DONE;
                    case (i_func)
                        F_GET: begin
                            if (in_bnd) begin
                                o_mem_raddr = idx_a;
                                n_state     = S_READ;
                            end else begin
                                n_status = ST_OOB;
                            end
                        end
                        F_SET: begin
                            if (in_bnd) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = idx_a;
                                o_mem_wdata = DATA_WIDTH'(i_write_value);
                            end else begin
                                n_status = ST_OOB;
                            end
                        end
                        F_APPEND: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_count[AW-1:0];
                                o_mem_wdata = DATA_WIDTH'(i_write_value);
                                n_count     = r_count + CW'(1);
                            end
                        end
                        F_OREM: begin
                            if (in_bnd) begin
                                n_count = cnt_dec;
                                if (not_last) begin
                                    // fetch the first word to move down
                                    o_mem_raddr = idx_a + AW'(1);
                                    n_idx       = idx_a;
                                    n_src       = idx_a + AW'(1);
                                    n_state     = S_SHIFT;
                                end
                            end else begin
                                n_status = ST_OOB;
                            end
                        end
                        F_SREM: begin
                            if (in_bnd) begin
                                n_count = cnt_dec;
                                if (not_last) begin
                                    o_mem_raddr = cnt_dec[AW-1:0];
                                    n_idx       = idx_a;
                                    n_state     = S_SWAP;
                                end
                            end else begin
                                n_status = ST_OOB;
                            end
                        end
                        F_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_rdata = RDATA_W'(i_mem_rdata);
                n_state = S_DONE;
            end
            S_SHIFT: begin
                // write the fetched word one place down, fetch the next one
                o_mem_we = 1'b1;
                if (i_step_lt) begin
                    n_idx       = r_src;
                    n_src       = i_step_inc[AW-1:0];
                    o_mem_raddr = i_step_inc[AW-1:0];
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SWAP: begin
                o_mem_we = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_src    <= n_src;
        r_status <= n_status;
        r_rdata  <= n_rdata;
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.status      = r_status;
    assign o_res.read_data   = r_rdata;
    assign o_res.count       = COUNT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_shift_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (XW'(r_src) <= XW'(r_count)))
        else $error("shift source beyond last entry");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted beat left sequencer idle");

endmodule

`default_nettype wire

// ----- hdl/indexed_list_table.sv -----
`default_nettype none

// Channel  | handshake                | payload
// ---------+--------------------------+--------------------------------------
// request  | i_in_valid / o_in_ready  | i_func, i_index, i_write_value
// result   | o_out_valid / i_out_ready| o_status, o_read_data, o_count
//
// Set, append, clear, unused codes and out-of-range requests: decided while idle.
// Get and swap remove of an inner entry: one registered memory read, then the result.
// Ordered remove: moves N entries down (up to CAPACITY-1),
// one entry per cycle through the single-port-write memory.
// Reset (i_rst_n low, synchronous) empties the list; stored words are kept.
// A stalled result waits in the output register while the next request runs.

module indexed_list_table #(
    parameter int CAPACITY   = ilt_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ilt_pkg::DATA_W_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ilt_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [ilt_pkg::INDEX_W-1:0]   i_index,
    input  wire logic [ilt_pkg::VALUE_W-1:0]   i_write_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [ilt_pkg::STATUS_W-1:0]  o_status,
    output logic      [ilt_pkg::RDATA_W-1:0]   o_read_data,
    output logic      [ilt_pkg::COUNT_W-1:0]   o_count
);

    import ilt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (INDEX_W > CW) ? INDEX_W : CW;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [DATA_WIDTH-1:0]   mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic [DATA_WIDTH-1:0]   mem_rdata;
    logic [XW-1:0]           step_a;
    logic [XW-1:0]           step_b;
    logic [XW-1:0]           step_inc;
    logic                    step_lt;
    logic                    res_valid;
    t_result                 res;
    logic                    res_take;

    logic                    r_out_valid, n_out_valid;
    t_result                 r_out;

    ilt_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ilt_step #(
        .W (XW)
    ) u_step (
        .i_a   (step_a),
        .i_b   (step_b),
        .o_inc (step_inc),
        .o_lt  (step_lt)
    );

    ilt_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_index       (i_index),
        .i_write_value (i_write_value),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata),
        .o_step_a      (step_a),
        .o_step_b      (step_b),
        .i_step_inc    (step_inc),
        .i_step_lt     (step_lt),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .i_res_take    (res_take)
    );

    // load the output register when it is empty or being drained
    assign res_take    = res_valid && (!r_out_valid || i_out_ready);
    assign n_out_valid = res_take || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_read_data = r_out.read_data;
    assign o_count     = r_out.count;

endmodule

`default_nettype wire

// ----- test/indexed_list_table_test.sv -----
`default_nettype none

module indexed_list_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ilt_pkg::*;

    localparam int LIST_DEPTH = CAPACITY_DEF;
    localparam int DRAIN_TAIL = 80;
    localparam logic [FUNC_W-1:0] F_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] F_RSVD7 = 3'd7;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_STEADY
    } t_mix;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [FUNC_W-1:0]   in_func = '0;
    logic [INDEX_W-1:0]  in_index = '0;
    logic [VALUE_W-1:0]  in_value = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] res_status;
    logic [RDATA_W-1:0]  res_rdata;
    logic [COUNT_W-1:0]  res_count;

    // Shadow copy of the list
    logic [VALUE_W-1:0]  list_mem [LIST_DEPTH];
    logic [COUNT_W-1:0]  list_len = '0;

    t_result pending_results[$];
    int      error_count = 0;
    int      burst_left = 0;
    int      holdoff_left = 0;
    int      rx_mode = 0;
    int      rx_phase_left = 0;
    int      rx_tick = 0;

    indexed_list_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_func        (in_func),
        .i_index       (in_index),
        .i_write_value (in_value),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (res_status),
        .o_read_data   (res_rdata),
        .o_count       (res_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result apply_list_op(input logic [FUNC_W-1:0] op,
                                              input logic [INDEX_W-1:0] idx,
                                              input logic [VALUE_W-1:0] wval);
        t_result            res;
        logic [COUNT_W-1:0] j;
        res.status    = ST_OK;
        res.read_data = '0;
        case (op)
            F_GET: begin
                if (idx < list_len) res.read_data = list_mem[idx];
                else res.status = ST_OOB;
            end
            F_SET: begin
                if (idx < list_len) list_mem[idx] = wval;
                else res.status = ST_OOB;
            end
            F_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_mem[list_len[INDEX_W-1:0]] = wval;
                    list_len = list_len + 1'b1;
                end
            end
            F_OREM: begin
                if (idx < list_len) begin
                    for (j = COUNT_W'(idx); j + 1'b1 < list_len; j++) begin
                        list_mem[j[INDEX_W-1:0]] = list_mem[INDEX_W'(j + 1'b1)];
                    end
                    list_len = list_len - 1'b1;
                end else begin
                    res.status = ST_OOB;
                end
            end
            F_SREM: begin
                if (idx < list_len) begin
                    list_len = list_len - 1'b1;
                    // the last entry fills the hole unless it was the one removed
                    if (idx != list_len) list_mem[idx] = list_mem[list_len[INDEX_W-1:0]];
                end else begin
                    res.status = ST_OOB;
                end
            end
            F_CLEAR: list_len = '0;
            default: ;
        endcase
        res.count = list_len;
        return res;
    endfunction

    // Send one beat; valid stays high on return so back-to-back beats need no bubble.
    task automatic issue_request(input logic [FUNC_W-1:0]  req_func,
                                 input logic [INDEX_W-1:0] req_index,
                                 input logic [VALUE_W-1:0] req_value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(6, 0);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(48, 16)
                                                    : $urandom_range(8, 1);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_func  <= req_func;
        in_index <= req_index;
        in_value <= req_value;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        pending_results.push_back(apply_list_op(req_func, req_index, req_value));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [FUNC_W-1:0] pick_func(input t_mix mix);
        int r;
        r = $urandom_range(99, 0);
        if (r == 0) return F_CLEAR;
        if (r == 1) return $urandom_range(1, 0) ? F_RSVD7 : F_RSVD6;
        case (mix)
            MIX_GROW: begin
                if (r < 50) return F_APPEND;
                if (r < 65) return F_GET;
                if (r < 80) return F_SET;
                if (r < 90) return F_OREM;
                return F_SREM;
            end
            MIX_SHRINK: begin
                if (r < 15) return F_APPEND;
                if (r < 30) return F_GET;
                if (r < 45) return F_SET;
                if (r < 72) return F_OREM;
                return F_SREM;
            end
            default: begin
                if (r < 30) return F_APPEND;
                if (r < 50) return F_GET;
                if (r < 65) return F_SET;
                if (r < 82) return F_OREM;
                return F_SREM;
            end
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        int r;
        r = $urandom_range(99, 0);
        if (list_len == 0 || r < 10) return INDEX_W'($urandom_range(LIST_DEPTH - 1, 0));
        if (r < 18 && list_len < LIST_DEPTH) return INDEX_W'(list_len);
        if (r < 28) return INDEX_W'(list_len - 1'b1);
        return INDEX_W'($urandom_range(list_len - 1, 0));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(9, 0);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom();
    endfunction

    task automatic test_directed_ops();
        issue_request(F_GET, 6'd0, '0);
        issue_request(F_SET, 6'd63, 32'hFFFF_FFFF);
        issue_request(F_OREM, 6'd0, '0);
        issue_request(F_SREM, 6'd0, '0);
        issue_request(F_APPEND, 6'd0, 32'h0000_0000);
        issue_request(F_APPEND, 6'd63, 32'hFFFF_FFFF);
        issue_request(F_APPEND, 6'd0, 32'hA5A5_A5A5);
        issue_request(F_APPEND, 6'd0, 32'h5A5A_5A5A);
        issue_request(F_GET, 6'd0, '0);
        issue_request(F_GET, 6'd1, '0);
        issue_request(F_SET, 6'd3, 32'hFFFF_FFFF);
        issue_request(F_GET, 6'd3, '0);
        // one past the end, and the top index
        issue_request(F_GET, 6'd4, '0);
        issue_request(F_SET, 6'd63, 32'h1234_5678);
        // swap remove of the tail only drops the count
        issue_request(F_SREM, 6'd3, '0);
        issue_request(F_GET, 6'd2, '0);
        // swap remove of the head pulls the tail into the hole
        issue_request(F_SREM, 6'd0, '0);
        issue_request(F_GET, 6'd0, '0);
        issue_request(F_OREM, 6'd0, '0);
        issue_request(F_GET, 6'd0, '0);
        issue_request(F_RSVD6, 6'd63, 32'hFFFF_FFFF);
        issue_request(F_RSVD7, 6'd0, '0);
        issue_request(F_CLEAR, 6'd0, '0);
        issue_request(F_GET, 6'd0, '0);
        drain_results();
    endtask

    task automatic test_fill_to_capacity();
        issue_request(F_CLEAR, 6'd0, '0);
        repeat (LIST_DEPTH) issue_request(F_APPEND, pick_index(), pick_value());
        issue_request(F_APPEND, 6'd0, 32'hDEAD_BEEF);
        issue_request(F_GET, 6'd63, '0);
        issue_request(F_SET, 6'd63, pick_value());
        // longest shift
        issue_request(F_OREM, 6'd0, '0);
        issue_request(F_GET, 6'd62, '0);
        issue_request(F_GET, 6'd63, '0);
        issue_request(F_SREM, 6'd0, '0);
        issue_request(F_GET, 6'd0, '0);
        repeat (3) issue_request(F_APPEND, 6'd0, pick_value());
        issue_request(F_SREM, 6'd63, '0);
        issue_request(F_OREM, 6'd62, '0);
        drain_results();
    endtask

    task automatic test_output_holdoff();
        holdoff_left = 400;
        repeat (40) issue_request(pick_func(MIX_STEADY), pick_index(), pick_value());
        drain_results();
    endtask

    task automatic test_random_traffic(input int n_items);
        t_mix mix;
        int   seg_left;
        mix = MIX_GROW;
        seg_left = 0;
        for (int k = 0; k < n_items; k++) begin
            if (seg_left == 0) begin
                mix = t_mix'($urandom_range(2, 0));
                seg_left = $urandom_range(60, 20);
            end
            seg_left--;
            issue_request(pick_func(mix), pick_index(), pick_value());
        end
        drain_results();
    endtask

    // Check each result beat and pick the next ready level.
    always @(posedge i_clk) begin : rx_side
        t_result want;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: status %0d count %0d",
                           res_status, res_count);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (res_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, res_status);
                        error_count++;
                    end
                    if (res_rdata !== want.read_data) begin
                        $error("read_data: expected %08h, actual %08h",
                               want.read_data, res_rdata);
                        error_count++;
                    end
                    if (res_count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, res_count);
                        error_count++;
                    end
                end
            end
            if (holdoff_left > 0) begin
                out_ready <= 1'b0;
                holdoff_left--;
            end else begin
                if (rx_phase_left == 0) begin
                    rx_mode = $urandom_range(3, 0);
                    rx_phase_left = $urandom_range(150, 30);
                end
                rx_phase_left--;
                rx_tick++;
                case (rx_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(1, 0));
                    2: out_ready <= ($urandom_range(3, 0) == 0);
                    default: out_ready <= (rx_tick % 4 == 0);
                endcase
            end
        end
    end

    initial begin
        #10_000_000;
        $display("indexed_list_table_test NOT OK");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_ops();
        test_fill_to_capacity();
        test_output_holdoff();
        test_random_traffic(1000);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("indexed_list_table_test OK");
        end else begin
            $display("indexed_list_table_test NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
